>>> hw/rtl/sem_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; the design files refer to it by scoped names, the testbench files import it.
package sem_pkg;

    localparam int PIX_W    = 8;
    localparam int LINE_W   = 2 * PIX_W;
    localparam int GRAD_W   = 10;
    localparam int SUM_W    = 2 * GRAD_W + 1;
    localparam int ROOT_W   = 8;
    localparam int WIDTH_W  = 9;
    localparam int HEIGHT_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int MIN_SIZE = 3;
    localparam int FIRST_INTERIOR = 2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 9'd256;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd256;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_GRAD,
        S_SQUARE,
        S_LAUNCH,
        S_ROOT
    } state_t;

    typedef struct packed {
        logic shift;
        logic grad_en;
        logic sq_en;
    } grad_ctrl_t;

endpackage

>>> hw/rtl/sem_line_mem.sv
`timescale 1ns / 1ps
// Line store memory: one entry per column holds the two previous lines.
// Synchronous read with a registered output. Depends on sem_pkg.
module sem_line_mem #(
    parameter int DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [sem_pkg::LINE_W-1:0]  wr_data,
    output logic [sem_pkg::LINE_W-1:0]  rd_data
);

    logic [sem_pkg::LINE_W-1:0] mem [DEPTH];
    logic [sem_pkg::LINE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/sem_grad.sv
`timescale 1ns / 1ps
// 3x3 window, Sobel kernels and sum of squared gradients.
// Depends on sem_pkg.
module sem_grad (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sem_pkg::grad_ctrl_t         ctrl,
    input  logic [sem_pkg::LINE_W-1:0]  line_data,
    input  logic [sem_pkg::PIX_W-1:0]   pixel,
    output logic [sem_pkg::SUM_W-1:0]   sum
);

    logic [sem_pkg::PIX_W-1:0]    win_reg [9];
    logic [sem_pkg::GRAD_W-1:0]   ax_reg;
    logic [sem_pkg::GRAD_W-1:0]   ay_reg;
    logic [sem_pkg::SUM_W-1:0]    sum_reg;

    logic [sem_pkg::GRAD_W:0]     gx_pos;
    logic [sem_pkg::GRAD_W:0]     gx_neg;
    logic [sem_pkg::GRAD_W:0]     gy_pos;
    logic [sem_pkg::GRAD_W:0]     gy_neg;
    logic [sem_pkg::GRAD_W:0]     gx_abs;
    logic [sem_pkg::GRAD_W:0]     gy_abs;
    logic [2*sem_pkg::GRAD_W-1:0] sq_x;
    logic [2*sem_pkg::GRAD_W-1:0] sq_y;
    logic [sem_pkg::SUM_W-1:0]    sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (ctrl.shift)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k*3]   <= win_reg[k*3+1];
                win_reg[k*3+1] <= win_reg[k*3+2];
            end
            win_reg[2] <= line_data[sem_pkg::LINE_W-1:sem_pkg::PIX_W];
            win_reg[5] <= line_data[sem_pkg::PIX_W-1:0];
            win_reg[8] <= pixel;
        end
    end

    always_comb
    begin
        gx_pos = (sem_pkg::GRAD_W+1)'(win_reg[2]) + (sem_pkg::GRAD_W+1)'({win_reg[5], 1'b0})
               + (sem_pkg::GRAD_W+1)'(win_reg[8]);
        gx_neg = (sem_pkg::GRAD_W+1)'(win_reg[0]) + (sem_pkg::GRAD_W+1)'({win_reg[3], 1'b0})
               + (sem_pkg::GRAD_W+1)'(win_reg[6]);
        gy_pos = (sem_pkg::GRAD_W+1)'(win_reg[6]) + (sem_pkg::GRAD_W+1)'({win_reg[7], 1'b0})
               + (sem_pkg::GRAD_W+1)'(win_reg[8]);
        gy_neg = (sem_pkg::GRAD_W+1)'(win_reg[0]) + (sem_pkg::GRAD_W+1)'({win_reg[1], 1'b0})
               + (sem_pkg::GRAD_W+1)'(win_reg[2]);
        gx_abs = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
        gy_abs = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.grad_en)
        begin
            ax_reg <= gx_abs[sem_pkg::GRAD_W-1:0];
            ay_reg <= gy_abs[sem_pkg::GRAD_W-1:0];
        end
    end

    assign sq_x     = ax_reg * ax_reg;
    assign sq_y     = ay_reg * ay_reg;
    assign sum_next = sem_pkg::SUM_W'(sq_x) + sem_pkg::SUM_W'(sq_y);

    always_ff @(posedge clk)
    begin
        if (ctrl.sq_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

>>> hw/rtl/sem_sqrt.sv
`timescale 1ns / 1ps
// Bit-serial floor square root, one result bit per cycle, saturating at 255.
// Depends on sem_pkg.
module sem_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sem_pkg::SUM_W-1:0]   value,
    output logic                        done,
    output logic [sem_pkg::ROOT_W-1:0]  root
);

    localparam int SQ_W = 2 * sem_pkg::ROOT_W;

    logic                        busy_reg;
    logic                        done_reg;
    logic [SQ_W-1:0]             val_reg;
    logic                        sat_reg;
    logic [sem_pkg::ROOT_W-1:0]  root_reg;
    logic [sem_pkg::ROOT_W-1:0]  bit_reg;

    logic [sem_pkg::ROOT_W-1:0]  trial;
    logic [SQ_W-1:0]             trial_sq;

    assign trial    = root_reg | bit_reg;
    assign trial_sq = trial * trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && bit_reg[0])
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value[SQ_W-1:0];
            sat_reg  <= |value[sem_pkg::SUM_W-1:SQ_W];
            root_reg <= '0;
            bit_reg  <= {1'b1, {(sem_pkg::ROOT_W-1){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (trial_sq <= val_reg)
            begin
                root_reg <= trial;
            end
            bit_reg <= bit_reg >> 1;
        end
    end

    assign done = done_reg;
    assign root = sat_reg ? {sem_pkg::ROOT_W{1'b1}} : root_reg;

endmodule

>>> hw/rtl/sobel_edge_magnitude.sv
`timescale 1ns / 1ps
// Streaming 3x3 Sobel edge magnitude over 8-bit raster pixels.
// Depends on sem_pkg, sem_line_mem, sem_grad and sem_sqrt.
//
// One pixel is processed at a time. A border pixel occupies the block for a
// line store read, then window shift and write-back; an interior pixel goes on
// through gradient, squaring and launch steps and the bit-serial square root,
// one result bit per cycle, then waits for a free output register. The result
// sits in an output register, so the next pixel is taken while a result waits
// on result_ready. Both line stores share one memory entry per column, read
// and rewritten once per pixel. Results exist only for pixels whose window
// center lies inside the frame; frame_last marks the final one. The line
// length is image_width clamped to 3..MAX_LINE_PIXELS and the frame height
// is image_height clamped to at least 3. Write configuration only while idle.
module sobel_edge_magnitude #(
    parameter int MAX_LINE_PIXELS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  logic [sem_pkg::PIX_W-1:0]       pixel_value,
    input  logic                            frame_start,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [sem_pkg::ROOT_W-1:0]      edge_magnitude,
    output logic                            frame_last
);

    localparam int COL_W = $clog2(MAX_LINE_PIXELS);
    localparam int CMP_W = (COL_W + 1 > sem_pkg::WIDTH_W) ? COL_W + 1 : sem_pkg::WIDTH_W;
    localparam logic [CMP_W-1:0] MAX_LINE = CMP_W'(MAX_LINE_PIXELS);
    localparam logic [CMP_W-1:0] MIN_LINE = CMP_W'(sem_pkg::MIN_SIZE);
    localparam logic [sem_pkg::HEIGHT_W-1:0] MIN_ROWS = sem_pkg::HEIGHT_W'(sem_pkg::MIN_SIZE);

    sem_pkg::state_t               state_reg;
    sem_pkg::state_t               state_next;

    logic [sem_pkg::WIDTH_W-1:0]   image_width_reg;
    logic [sem_pkg::HEIGHT_W-1:0]  image_height_reg;
    logic [COL_W-1:0]              column_count_reg;
    logic [sem_pkg::HEIGHT_W-1:0]  row_count_reg;

    logic [sem_pkg::PIX_W-1:0]     px_reg;
    logic [COL_W-1:0]              col_reg;
    logic                          interior_reg;
    logic                          last_reg;

    logic                          result_valid_reg;
    logic [sem_pkg::ROOT_W-1:0]    edge_reg;
    logic                          frame_last_reg;

    logic                          accept;
    logic [COL_W-1:0]              col_cur;
    logic [sem_pkg::HEIGHT_W-1:0]  row_cur;
    logic [CMP_W-1:0]              width_ext;
    logic [CMP_W-1:0]              width_eff;
    logic [sem_pkg::HEIGHT_W-1:0]  height_eff;
    logic                          end_line;
    logic                          end_frame;
    logic                          interior;

    sem_pkg::grad_ctrl_t           grad_ctrl;
    logic                          mem_wr_en;
    logic [sem_pkg::LINE_W-1:0]    line_data;
    logic [sem_pkg::SUM_W-1:0]     grad_sum;
    logic                          root_start;
    logic                          root_done;
    logic [sem_pkg::ROOT_W-1:0]    root_value;
    logic                          load_out;
    logic                          out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= sem_pkg::WIDTH_RESET;
            image_height_reg <= sem_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                sem_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[sem_pkg::WIDTH_W-1:0];
                sem_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[sem_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept    = pixel_valid && pixel_ready;
    assign col_cur   = frame_start ? '0 : column_count_reg;
    assign row_cur   = frame_start ? '0 : row_count_reg;
    assign width_ext = CMP_W'(image_width_reg);

    always_comb
    begin
        if (width_ext < MIN_LINE)
        begin
            width_eff = MIN_LINE;
        end
        else if (width_ext > MAX_LINE)
        begin
            width_eff = MAX_LINE;
        end
        else
        begin
            width_eff = width_ext;
        end
        height_eff = (image_height_reg < MIN_ROWS) ? MIN_ROWS : image_height_reg;
        end_line   = CMP_W'(col_cur) >= (width_eff - CMP_W'(1));
        end_frame  = end_line && (row_cur >= (height_eff - sem_pkg::HEIGHT_W'(1)));
        interior   = (row_cur >= sem_pkg::HEIGHT_W'(sem_pkg::FIRST_INTERIOR))
                  && (col_cur >= COL_W'(sem_pkg::FIRST_INTERIOR));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (accept)
        begin
            if (end_line)
            begin
                column_count_reg <= '0;
                row_count_reg    <= end_frame ? '0 : row_cur + sem_pkg::HEIGHT_W'(1);
            end
            else
            begin
                column_count_reg <= col_cur + COL_W'(1);
                row_count_reg    <= row_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg       <= pixel_value;
            col_reg      <= col_cur;
            interior_reg <= interior;
            last_reg     <= end_frame;
        end
    end

    sem_line_mem #(
        .DEPTH   (MAX_LINE_PIXELS)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .wr_en   (mem_wr_en),
        .wr_addr (col_reg),
        .wr_data ({line_data[sem_pkg::PIX_W-1:0], px_reg}),
        .rd_data (line_data)
    );

    sem_grad u_grad (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (grad_ctrl),
        .line_data (line_data),
        .pixel     (px_reg),
        .sum       (grad_sum)
    );

    sem_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (grad_sum),
        .done  (root_done),
        .root  (root_value)
    );

    assign out_free = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sem_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        grad_ctrl   = '0;
        mem_wr_en   = 1'b0;
        root_start  = 1'b0;
        load_out    = 1'b0;
        pixel_ready = 1'b0;
        case (state_reg)
            sem_pkg::S_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid)
                begin
                    state_next = sem_pkg::S_SHIFT;
                end
            end
            sem_pkg::S_SHIFT:
            begin
                grad_ctrl.shift = 1'b1;
                mem_wr_en       = 1'b1;
                state_next      = interior_reg ? sem_pkg::S_GRAD : sem_pkg::S_IDLE;
            end
            sem_pkg::S_GRAD:
            begin
                grad_ctrl.grad_en = 1'b1;
                state_next        = sem_pkg::S_SQUARE;
            end
            sem_pkg::S_SQUARE:
            begin
                grad_ctrl.sq_en = 1'b1;
                state_next      = sem_pkg::S_LAUNCH;
            end
            sem_pkg::S_LAUNCH:
            begin
                root_start = 1'b1;
                state_next = sem_pkg::S_ROOT;
            end
            sem_pkg::S_ROOT:
            begin
                if (root_done && out_free)
                begin
                    load_out   = 1'b1;
                    state_next = sem_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sem_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            edge_reg       <= root_value;
            frame_last_reg <= last_reg;
        end
    end

    assign result_valid   = result_valid_reg;
    assign edge_magnitude = edge_reg;
    assign frame_last     = frame_last_reg;

endmodule

>>> hw/rtl/sem_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the Sobel edge magnitude block, bound to the top.
// Depends on sem_pkg and sobel_edge_magnitude.
module sem_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        pixel_valid,
    input logic                        pixel_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [sem_pkg::ROOT_W-1:0]  edge_magnitude,
    input logic                        frame_last
);

    // one pixel in flight: busy right after a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !pixel_ready)
        else $error("pixel taken while previous pixel still in work");

    // a result appears only as the block returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> pixel_ready && !$past(pixel_ready))
        else $error("result raised outside the end of a pixel's work");

    // no result can follow a beat in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !$rose(result_valid))
        else $error("result raised right after a pixel beat");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(edge_magnitude) && $stable(frame_last))
        else $error("stalled result changed or dropped");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);

>>> tb/edge_result_check.sv
`timescale 1ns / 1ps
// Predictor and comparator for the Sobel edge magnitude block.
// Watches the register, pixel and result ports; depends on sem_pkg only.
module edge_result_check #(
    parameter int LINE_PIXELS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            pixel_valid,
    input  logic                            pixel_ready,
    input  logic [sem_pkg::PIX_W-1:0]       pixel_value,
    input  logic                            frame_start,
    input  logic                            result_valid,
    input  logic                            result_ready,
    input  logic [sem_pkg::ROOT_W-1:0]      edge_magnitude,
    input  logic                            frame_last,
    output int                              mismatches,
    output int                              outstanding,
    output int                              compared
);
    import sem_pkg::*;

    typedef struct packed {
        logic [ROOT_W-1:0] magnitude;
        logic              last;
    } edge_result_t;

    edge_result_t            expected_edges[$];
    logic [PIX_W-1:0]        older_line [0:LINE_PIXELS-1];
    logic [PIX_W-1:0]        newer_line [0:LINE_PIXELS-1];
    logic [PIX_W-1:0]        window [0:2][0:2];
    logic [WIDTH_W-1:0]      width_reg;
    logic [HEIGHT_W-1:0]     height_reg;
    int unsigned             col_pos;
    int unsigned             row_pos;
    int                      error_total;
    int                      compare_total;

    // Shift the window, update both lines and queue the magnitude of an interior center.
    task automatic predict_edge(input logic [PIX_W-1:0] px, input logic restart);
        int unsigned line_len;
        int unsigned frame_rows;
        int unsigned col;
        int unsigned energy;
        int unsigned root;
        int unsigned trial;
        int          gx;
        int          gy;
        bit          line_done;
        bit          frame_done;
        edge_result_t fresh;
        line_len = width_reg;
        if (line_len < MIN_SIZE)
            line_len = MIN_SIZE;
        if (line_len > LINE_PIXELS)
            line_len = LINE_PIXELS;
        frame_rows = (height_reg < MIN_SIZE) ? MIN_SIZE : height_reg;
        if (restart)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        col = (col_pos >= LINE_PIXELS) ? LINE_PIXELS - 1 : col_pos;
        for (int r = 0; r < 3; r++)
        begin
            window[r][0] = window[r][1];
            window[r][1] = window[r][2];
        end
        window[0][2] = older_line[col];
        window[1][2] = newer_line[col];
        window[2][2] = px;
        older_line[col] = newer_line[col];
        newer_line[col] = px;
        line_done  = (col >= line_len - 1);
        frame_done = line_done && (row_pos >= frame_rows - 1);
        if (row_pos >= FIRST_INTERIOR && col >= FIRST_INTERIOR)
        begin
            gx = (int'(window[0][2]) + 2 * int'(window[1][2]) + int'(window[2][2]))
               - (int'(window[0][0]) + 2 * int'(window[1][0]) + int'(window[2][0]));
            gy = (int'(window[2][0]) + 2 * int'(window[2][1]) + int'(window[2][2]))
               - (int'(window[0][0]) + 2 * int'(window[0][1]) + int'(window[0][2]));
            energy = gx * gx + gy * gy;
            root = 0;
            if (energy >= 65536)
                root = 255;
            else
            begin
                for (int b = ROOT_W - 1; b >= 0; b--)
                begin
                    trial = root | (1 << b);
                    if (trial * trial <= energy)
                        root = trial;
                end
            end
            fresh.magnitude = root[ROOT_W-1:0];
            fresh.last      = frame_done;
            expected_edges.push_back(fresh);
        end
        if (line_done)
        begin
            col_pos = 0;
            row_pos = frame_done ? 0 : ((row_pos + 1) & 32'hFFFF);
        end
        else
            col_pos = col + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        edge_result_t oldest;
        if (!rst_n)
        begin
            expected_edges.delete();
            for (int i = 0; i < LINE_PIXELS; i++)
            begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    window[r][c] = '0;
            col_pos       = 0;
            row_pos       = 0;
            width_reg     = WIDTH_RESET;
            height_reg    = HEIGHT_RESET;
            error_total   = 0;
            compare_total = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_edges.size() == 0)
                begin
                    $display("%0t: unexpected edge beat: magnitude %0d last %0b, none expected",
                             $time, edge_magnitude, frame_last);
                    error_total++;
                end
                else
                begin
                    oldest = expected_edges.pop_front();
                    compare_total++;
                    if (edge_magnitude !== oldest.magnitude)
                    begin
                        $display("%0t: edge_magnitude expected %0d, got %0d",
                                 $time, oldest.magnitude, edge_magnitude);
                        error_total++;
                    end
                    if (frame_last !== oldest.last)
                    begin
                        $display("%0t: frame_last expected %0b, got %0b",
                                 $time, oldest.last, frame_last);
                        error_total++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data[WIDTH_W-1:0];
                else if (cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = cfg_data[HEIGHT_W-1:0];
            end
            if (pixel_valid && pixel_ready)
                predict_edge(pixel_value, frame_start);
        end
        mismatches  <= error_total;
        outstanding <= expected_edges.size();
        compared    <= compare_total;
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top of the Sobel edge magnitude testbench: clock, reset, pixel stimulus and verdict.
// Depends on sem_pkg, sobel_edge_magnitude and edge_result_check.
module tb;
    import sem_pkg::*;

    localparam int LINE_PIXELS   = 256;
    localparam int RANDOM_PIXELS = 120;
    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  pixel_valid;
    logic                  pixel_ready;
    logic [PIX_W-1:0]      pixel_value;
    logic                  frame_start;
    logic                  result_valid;
    logic                  result_ready;
    logic [ROOT_W-1:0]     edge_magnitude;
    logic                  frame_last;

    int mismatches;
    int outstanding;
    int compared;
    int pixels_sent   = 0;
    int geometries    = 0;
    int cycle_count   = 0;
    int active_width  = LINE_PIXELS;
    bit restart_frame = 1'b0;
    bit tx_calm       = 1'b0;
    bit rx_calm       = 1'b0;
    bit hold_request  = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    sobel_edge_magnitude #(
        .MAX_LINE_PIXELS(LINE_PIXELS)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .pixel_value    (pixel_value),
        .frame_start    (frame_start),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .edge_magnitude (edge_magnitude),
        .frame_last     (frame_last)
    );

    edge_result_check #(
        .LINE_PIXELS(LINE_PIXELS)
    ) edge_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .pixel_value    (pixel_value),
        .frame_start    (frame_start),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .edge_magnitude (edge_magnitude),
        .frame_last     (frame_last),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .compared       (compared)
    );

    function automatic logic [PIX_W-1:0] pick_pixel();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Write width and height; restart the frame after a width increase so no unwritten line entry is read.
    task automatic write_geometry(input logic [WIDTH_W-1:0] w, input logic [HEIGHT_W-1:0] h);
        int eff;
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= {{(CFG_W - WIDTH_W){1'b0}}, w};
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        eff = (w < MIN_SIZE) ? MIN_SIZE : ((w > LINE_PIXELS) ? LINE_PIXELS : w);
        if (eff > active_width)
            restart_frame = 1'b1;
        active_width = eff;
        geometries++;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid   <= 1'b1;
        pixel_value   <= px;
        frame_start   <= fs | restart_frame;
        restart_frame = 1'b0;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        pixels_sent++;
        if (pixels_sent % 40 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
    endtask

    // Drop valid and hold until every expected beat is back and the block is quiet.
    task automatic settle();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int stall;
        int beats;
        beats = 0;
        result_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, 6);
            if (hold_request)
            begin
                stall = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            beats++;
            if (beats % 32 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        int random_sent;
        int phase;
        int span;
        logic [WIDTH_W-1:0]  w;
        logic [HEIGHT_W-1:0] h;
        random_sent = 0;
        phase       = 0;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_IMAGE_WIDTH;
        cfg_data    <= '0;
        pixel_valid <= 1'b0;
        pixel_value <= '0;
        frame_start <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Sizes below the minimum clamp to a 3x3 frame.
        write_geometry(9'd0, 16'd1);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 3 == 2) ? 8'hFF : 8'h00, i == 0);
        for (int i = 0; i < 9; i++)
            send_pixel(8'(10 * (i % 3 + 1)), 1'b0);
        send_pixel(8'd77, 1'b0);
        send_pixel(8'd200, 1'b0);
        for (int i = 0; i < 9; i++)
            send_pixel(8'hFF, i == 0);
        settle();

        // Oversized width clamps to a full line; then shrink and finish the frame.
        write_geometry(9'h1FF, 16'd3);
        for (int i = 0; i < LINE_PIXELS; i++)
            send_pixel(pick_pixel(), 1'b0);
        settle();
        write_geometry(9'd3, 16'd3);
        for (int i = 0; i < 6; i++)
            send_pixel(pick_pixel(), 1'b0);
        settle();

        while (random_sent < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 5))
                0:       w = 9'd3;
                1:       w = 9'($urandom_range(0, 2));
                2:       w = 9'($urandom_range(12, 20));
                default: w = 9'($urandom_range(4, 9));
            endcase
            case ($urandom_range(0, 6))
                0:       h = 16'($urandom_range(0, 2));
                1:       h = 16'd3;
                2:       h = 16'hFFFF;
                3:       h = 16'($urandom_range(9, 65534));
                default: h = 16'($urandom_range(4, 8));
            endcase
            if (phase == 0 || phase == 2)
            begin
                w = 9'd5;
                h = 16'hFFFF;
            end
            write_geometry(w, h);
            span = $urandom_range(25, 55);
            for (int i = 0; i < span; i++)
            begin
                if (phase == 2 && i == 10)
                    hold_request = 1'b1;
                send_pixel(pick_pixel(),
                           (i == 0) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 39) == 0));
                random_sent++;
            end
            settle();
            phase++;
        end

        $display("Sent %0d pixels under %0d geometry settings; %0d edge beats compared.",
                 pixels_sent, geometries, compared);
        $display("Covered clamped sizes, saturation, mid-frame restarts and a %0d-cycle stall.",
                 LONG_HOLD);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/sem_pkg.sv
hw/rtl/sem_line_mem.sv
hw/rtl/sem_grad.sv
hw/rtl/sem_sqrt.sv
hw/rtl/sobel_edge_magnitude.sv
hw/rtl/sem_checker.sv
tb/edge_result_check.sv
tb/tb.sv
